>>> rtl/core/sqto_pkg.sv
package sqto_pkg;

  localparam int unsigned QueueDepth = 8;
  localparam int unsigned IdxW       = $clog2(QueueDepth);
  localparam int unsigned PosW       = 3;
  localparam int unsigned CmpW       = (IdxW > PosW) ? IdxW : PosW;
  localparam int unsigned IdW        = 8;
  localparam int unsigned PriW       = 8;
  localparam int unsigned TimeW      = 31;
  localparam int unsigned StW        = 3;
  localparam int unsigned CntOutW    = 3;
  localparam int unsigned SDataW     = 56;
  localparam int unsigned MDataW     = 24;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_CHANGE = 2'd2,
    OP_REMOVE = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_BADPOS   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_PUSH_WALK,
    S_REM_WALK,
    S_RESP
  } state_e;

  typedef enum logic [1:0] {
    RD_REQ,
    RD_BELOW,
    RD_ABOVE
  } rd_sel_e;

  typedef struct packed {
    logic [TimeW-1:0] wake_time;
    logic [PriW-1:0]  priority_val;
    logic [IdW-1:0]   task_id;
  } entry_t;

  typedef struct packed {
    logic    start;
    rd_sel_e rd_sel;
    logic    set_st;
    status_e st;
    logic    init_push;
    logic    init_rem;
    logic    write_pri;
    logic    shift_up;
    logic    place;
    logic    shift_down;
    logic    shrink;
    logic    emit;
  } dp_cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    full;
    logic    empty;
    logic    bad_pos;
    logic    id_match;
    logic    push_stop;
    logic    rem_stop;
    logic    out_free;
  } dp_stat_t;

endpackage

>>> rtl/core/sleep_queue_time_ordered.sv
// Sleep queue of task entries kept in ascending wake-time order.
// Input beats on s_axis: tuser carries the opcode (push, pop head, change
// priority at a position, remove at a position); tdata carries task id,
// priority, wake time and position. Every beat yields one output beat on
// m_axis with the removed id and priority, a status code and the entry count.
// The queue holds up to QUEUE_DEPTH-1 entries; equal times keep arrival order.
// One item at a time: s_axis_tready is high only while the controller idles.
// An item that fails or is a change goes from evaluation straight to its
// result; push, pop and remove first run the insert or compaction walk,
// which moves one entry per cycle through a single entry read port.
// Results sit in an output register; a stalled m_axis holds the beat, and the
// next item can be accepted meanwhile but completes only once that slot frees.
// Reset empties the queue and drops any pending result; entry storage itself
// is not cleared.
module sleep_queue_time_ordered (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [7:0] task_id, [15:8] priority_req, [46:16] wake_time, [49:47] position
  input  logic [sqto_pkg::SDataW-1:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]                  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [7:0] out_task_id, [15:8] out_priority, [18:16] status, [21:19] entry_count
  output logic [sqto_pkg::MDataW-1:0] m_axis_tdata
);
  import sqto_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sqto_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  sqto_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_opcode_i (s_axis_tuser),
    .s_data_i   (s_axis_tdata),
    .m_ready_i  (m_axis_tready),
    .m_valid_o  (m_axis_tvalid),
    .m_data_o   (m_axis_tdata),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule

>>> rtl/core/sqto_ctrl.sv
module sqto_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  sqto_pkg::dp_stat_t stat_i,
  output sqto_pkg::dp_cmd_t  cmd_o
);
  import sqto_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) state_d = S_EVAL;
      end
      S_EVAL: begin
        unique case (stat_i.op)
          OP_PUSH:   state_d = stat_i.full ? S_RESP : S_PUSH_WALK;
          OP_POP:    state_d = stat_i.empty ? S_RESP : S_REM_WALK;
          OP_CHANGE: state_d = S_RESP;
          OP_REMOVE: state_d = (stat_i.empty || stat_i.bad_pos) ? S_RESP : S_REM_WALK;
          default:   state_d = S_RESP;
        endcase
      end
      S_PUSH_WALK: begin
        if (stat_i.push_stop) state_d = S_RESP;
      end
      S_REM_WALK: begin
        if (stat_i.rem_stop) state_d = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    cmd_o.st  = ST_OK;
    cmd_o.rd_sel = RD_REQ;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o   = 1'b1;
        cmd_o.start = s_valid_i;
      end
      S_EVAL: begin
        unique case (stat_i.op)
          OP_PUSH: begin
            if (stat_i.full) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = ST_FULL;
            end else begin
              cmd_o.init_push = 1'b1;
            end
          end
          OP_POP: begin
            if (stat_i.empty) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = ST_EMPTY;
            end else begin
              cmd_o.init_rem = 1'b1;
            end
          end
          OP_CHANGE: begin
            if (stat_i.bad_pos) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = ST_BADPOS;
            end else if (!stat_i.id_match) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = ST_MISMATCH;
            end else begin
              cmd_o.write_pri = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (stat_i.empty) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = ST_EMPTY;
            end else if (stat_i.bad_pos) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = ST_BADPOS;
            end else begin
              cmd_o.init_rem = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_PUSH_WALK: begin
        cmd_o.rd_sel = RD_BELOW;
        if (stat_i.push_stop) cmd_o.place = 1'b1;
        else                  cmd_o.shift_up = 1'b1;
      end
      S_REM_WALK: begin
        cmd_o.rd_sel = RD_ABOVE;
        if (stat_i.rem_stop) cmd_o.shrink = 1'b1;
        else                 cmd_o.shift_down = 1'b1;
      end
      S_RESP: begin
        cmd_o.emit = stat_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/sqto_dp.sv
module sqto_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [1:0]                  s_opcode_i,
  input  logic [sqto_pkg::SDataW-1:0] s_data_i,
  input  logic                        m_ready_i,
  output logic                        m_valid_o,
  output logic [sqto_pkg::MDataW-1:0] m_data_o,
  input  sqto_pkg::dp_cmd_t           cmd_i,
  output sqto_pkg::dp_stat_t          stat_o
);
  import sqto_pkg::*;

  entry_t               ent_q [QueueDepth];
  logic [IdxW-1:0]      cnt_q, cnt_d;
  logic [IdxW-1:0]      k_q, k_d;
  opcode_e              op_q;
  logic [IdW-1:0]       id_q;
  logic [PriW-1:0]      pri_q;
  logic [TimeW-1:0]     tm_q;
  logic [PosW-1:0]      pos_q;
  status_e              st_q;
  logic [IdW-1:0]       oid_q;
  logic [PriW-1:0]      opr_q;
  logic                 m_valid_q;
  logic [MDataW-1:0]    m_data_q;
  logic [IdxW-1:0]      req_idx;
  logic [IdxW-1:0]      rd_idx;
  entry_t               rd_ent;
  logic [IdxW-1:0]      k_up;

  assign req_idx = (op_q == OP_POP) ? '0 : IdxW'(pos_q);
  assign k_up    = k_q + IdxW'(1);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_BELOW: rd_idx = k_q - IdxW'(1);
      RD_ABOVE: rd_idx = k_up;
      default:  rd_idx = req_idx;
    endcase
  end

  assign rd_ent = ent_q[rd_idx];

  always_comb begin
    stat_o.op        = op_q;
    stat_o.full      = (cnt_q == IdxW'(QueueDepth - 1));
    stat_o.empty     = (cnt_q == '0);
    stat_o.bad_pos   = (CmpW'(pos_q) >= CmpW'(cnt_q));
    stat_o.id_match  = (rd_ent.task_id == id_q);
    stat_o.push_stop = (k_q == '0) || !(rd_ent.wake_time > tm_q);
    stat_o.rem_stop  = ((CmpW + 1)'(k_q) + (CmpW + 1)'(1) >= (CmpW + 1)'(cnt_q));
    stat_o.out_free  = !m_valid_q || m_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_up || cmd_i.shift_down) begin
      ent_q[k_q] <= rd_ent;
    end
    if (cmd_i.place) begin
      ent_q[k_q] <= '{wake_time: tm_q, priority_val: pri_q, task_id: id_q};
    end
    if (cmd_i.write_pri) begin
      ent_q[req_idx].priority_val <= pri_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q  <= opcode_e'(s_opcode_i);
      id_q  <= s_data_i[7:0];
      pri_q <= s_data_i[15:8];
      tm_q  <= s_data_i[46:16];
      pos_q <= s_data_i[49:47];
      st_q  <= ST_OK;
      oid_q <= '0;
      opr_q <= '0;
    end else begin
      if (cmd_i.set_st) st_q <= cmd_i.st;
      if (cmd_i.init_rem) begin
        oid_q <= rd_ent.task_id;
        opr_q <= rd_ent.priority_val;
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    k_d   = k_q;
    if (cmd_i.init_push) k_d = cnt_q;
    if (cmd_i.init_rem)  k_d = req_idx;
    if (cmd_i.shift_up)  k_d = k_q - IdxW'(1);
    if (cmd_i.shift_down) k_d = k_up;
    if (cmd_i.place)     cnt_d = cnt_q + IdxW'(1);
    if (cmd_i.shrink)    cnt_d = cnt_q - IdxW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      k_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      k_q   <= k_d;
      if (cmd_i.emit) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      m_data_q <= {2'b00, CntOutW'(cnt_q), st_q, opr_q, oid_q};
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

endmodule
